### rtl/shuca_pkg.sv
// shuca_pkg: shared constants for the shader microcode rotate-add hash
// used by shader_ucode_rotate_add_hash_core and its port checker
// no dependencies

package shuca_pkg;

    // data path widths
    localparam int HASH_W = 64;
    localparam int CNT_W  = 5;
    localparam int ROT_W  = 6;

    // source type field code for a constant operand
    localparam logic [1:0] SRC_TYPE_CONST = 2'd2;

    // hash_mode register codes
    localparam logic MODE_FRAGMENT = 1'b0;
    localparam logic MODE_VERTEX   = 1'b1;

endpackage

### rtl/shader_ucode_rotate_add_hash_core.sv
// shader_ucode_rotate_add_hash_core: rotate-add checksum over 128-bit instruction slots
// depends on shuca_pkg for widths and codes
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  input    | in        | i_in_valid / o_in_stall   | i_slot_low, i_slot_high,
//           |           |                           | i_slot_used, i_last_slot
//  output   | out       | o_out_valid / i_out_stall | o_hash_value
//  config   | in        | i_cfg_we                  | i_cfg_data (hash_mode)
//
// one slot per cycle while o_in_stall is low: an input register, then one rotate and
// add stage into the accumulators and the result register, which holds the final hash
// i_rst_n is synchronous, active low, and clears the pipeline, accumulators and mode
// o_in_stall rises only when a last slot waits behind a result that is held by i_out_stall

module shader_ucode_rotate_add_hash_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [shuca_pkg::HASH_W-1:0] i_slot_low,
    input  logic [shuca_pkg::HASH_W-1:0] i_slot_high,
    input  logic                        i_slot_used,
    input  logic                        i_last_slot,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [shuca_pkg::HASH_W-1:0] o_hash_value
);

    // input register stage
    logic                         r_s1_valid;
    logic [shuca_pkg::HASH_W-1:0] r_s1_low;
    logic [shuca_pkg::HASH_W-1:0] r_s1_high;
    logic                         r_s1_used;
    logic                         r_s1_last;

    // hash state
    logic                         r_mode;
    logic [shuca_pkg::HASH_W-1:0] r_acc_low;
    logic [shuca_pkg::HASH_W-1:0] r_acc_high;
    logic [shuca_pkg::CNT_W-1:0]  r_slot_count;
    logic                         r_skip_next;

    // result register
    logic                         r_out_valid;
    logic [shuca_pkg::HASH_W-1:0] r_hash_value;

    // combinational next values
    logic                         w_in_xfer;
    logic                         w_out_free;
    logic                         w_s1_adv;
    logic                         w_const_src;
    logic                         w_do_hash;
    logic                         n_skip_next;
    logic [shuca_pkg::ROT_W-1:0]  w_rot_low;
    logic [shuca_pkg::ROT_W-1:0]  w_rot_high;
    logic [2*shuca_pkg::HASH_W-1:0] w_dbl_low;
    logic [2*shuca_pkg::HASH_W-1:0] w_dbl_high;
    logic [shuca_pkg::HASH_W-1:0] w_rotated_low;
    logic [shuca_pkg::HASH_W-1:0] w_rotated_high;
    logic [shuca_pkg::HASH_W-1:0] n_acc_low;
    logic [shuca_pkg::HASH_W-1:0] n_acc_high;
    logic [shuca_pkg::HASH_W-1:0] n_hash_value;

    // flow control: only a last slot needs room in the result register
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_adv    = r_s1_valid && (!r_s1_last || w_out_free);
    assign o_in_stall  = r_s1_valid && !w_s1_adv;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_hash_value = r_hash_value;

    // constant source test on words 1, 2 and 3
    assign w_const_src = (r_s1_low[41:40]  == shuca_pkg::SRC_TYPE_CONST)
                      || (r_s1_high[9:8]   == shuca_pkg::SRC_TYPE_CONST)
                      || (r_s1_high[41:40] == shuca_pkg::SRC_TYPE_CONST);

    // slot selection per mode
    always_comb begin
        if (r_mode == shuca_pkg::MODE_VERTEX) begin
            w_do_hash   = r_s1_used;
            n_skip_next = 1'b0;
        end else if (r_skip_next) begin
            w_do_hash   = 1'b0;
            n_skip_next = 1'b0;
        end else begin
            w_do_hash   = 1'b1;
            n_skip_next = w_const_src;
        end
    end

    // rotate amounts 2i and 2i+1, both mod 64
    assign w_rot_low  = {r_slot_count, 1'b0};
    assign w_rot_high = {r_slot_count, 1'b1};

    // rotate right through a doubled word
    assign w_dbl_low      = {r_s1_low, r_s1_low} >> w_rot_low;
    assign w_dbl_high     = {r_s1_high, r_s1_high} >> w_rot_high;
    assign w_rotated_low  = w_dbl_low[shuca_pkg::HASH_W-1:0];
    assign w_rotated_high = w_dbl_high[shuca_pkg::HASH_W-1:0];

    // accumulate and form the final sum
    always_comb begin
        n_acc_low  = r_acc_low;
        n_acc_high = r_acc_high;
        if (w_do_hash) begin
            n_acc_low  = r_acc_low + w_rotated_low;
            n_acc_high = r_acc_high + w_rotated_high;
        end
        n_hash_value = n_acc_low + n_acc_high;
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= shuca_pkg::MODE_FRAGMENT;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input payload, loaded on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_low  <= i_slot_low;
            r_s1_high <= i_slot_high;
            r_s1_used <= i_slot_used;
            r_s1_last <= i_last_slot;
        end
    end

    // accumulator state, cleared at the end of a program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_low    <= '0;
            r_acc_high   <= '0;
            r_slot_count <= '0;
            r_skip_next  <= 1'b0;
        end else if (w_s1_adv) begin
            if (r_s1_last) begin
                r_acc_low    <= '0;
                r_acc_high   <= '0;
                r_slot_count <= '0;
                r_skip_next  <= 1'b0;
            end else begin
                r_acc_low    <= n_acc_low;
                r_acc_high   <= n_acc_high;
                r_slot_count <= r_slot_count + {{(shuca_pkg::CNT_W-1){1'b0}}, 1'b1};
                r_skip_next  <= n_skip_next;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_last) begin
            r_hash_value <= n_hash_value;
        end
    end

endmodule

### rtl/shuca_port_checker.sv
// shuca_port_checker: port-level checks for the rotate-add hash core
// depends on shuca_pkg; bound to shader_ucode_rotate_add_hash_core

module shuca_port_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_last_slot,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [shuca_pkg::HASH_W-1:0] o_hash_value
);

    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a new result follows a last slot transfer through the input and result registers
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_slot, 2))
        else $error("result without a last slot transfer");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hash_value)))
        else $error("stalled result changed");

endmodule

bind shader_ucode_rotate_add_hash_core shuca_port_checker u_shuca_port_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_slot  (i_last_slot),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hash_value (o_hash_value)
);
